// ===== hw/rtl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Metric cache package
// Shared types and codes of the direct-mapped metric cache.
// ----------------------------------------------------------------------------
package mcc_pkg;

   // default table size and internal queue depths
   localparam int ENTRIES_DEF = 2048;
   localparam int CMDQ_DEPTH  = 2;
   localparam int RSPQ_DEPTH  = 2;

   // request mode codes
   localparam logic [2:0] MODE_LOOKUP_W = 3'd0;
   localparam logic [2:0] MODE_LOOKUP_H = 3'd1;
   localparam logic [2:0] MODE_FILL_W   = 3'd2;
   localparam logic [2:0] MODE_FILL_H   = 3'd3;
   localparam logic [2:0] MODE_INVAL    = 3'd4;
   localparam logic [2:0] MODE_TICK     = 3'd5;

   // decoded operation
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOOKUP,
      OP_FILL,
      OP_INVAL,
      OP_TICK
   } op_type;

   // request word
   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] obj_addr;
      logic [31:0] text_addr;
      logic [31:0] text_hash;
      logic [63:0] fill_value;
   } req_type;

   // response word
   typedef struct packed {
      logic        hit;
      logic [63:0] result_value;
   } rsp_type;

   // classified command from front to back
   typedef struct packed {
      op_type      op;
      logic        height;
      logic [31:0] obj;
      logic [31:0] text;
      logic [31:0] hash;
      logic [63:0] value;
   } cmd_type;

   // one row of the tag store
   typedef struct packed {
      logic [31:0] obj;
      logic [31:0] text;
      logic [31:0] hash;
      logic [31:0] frame;
      logic        w_valid;
      logic        h_valid;
   } tag_row_type;

endpackage

// ===== hw/rtl/direct_mapped_metric_cache_unit.sv =====
// Issue: the back end takes a new request only once the last one has been
// through the tag store's read cycle and its compare/write cycle, and only
// while the response queue is not full.
// Reset: synchronous; afterwards a sweep clears the tag store, and full
// stays high until it is done.
// ----------------------------------------------------------------------------
// Direct-mapped metric cache
// Top level: front end, command queue, back end and response queue.
// ----------------------------------------------------------------------------
module direct_mapped_metric_cache_unit #(
   parameter int ENTRIES = mcc_pkg::ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  mcc_pkg::req_type req_word,
   output logic             empty,
   input  logic             pop,
   output mcc_pkg::rsp_type rsp_word
);
   import mcc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic             cmd_valid_w, cmd_pop_w, clear_busy_w;
   cmd_type          cmd_word_w;
   logic [IDX_W-1:0] cmd_idx_w;
   logic             rsp_full_w, rsp_push_w;
   rsp_type          rsp_in_w;

   mcc_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_word   (req_word),
      .clear_busy (clear_busy_w),
      .cmd_valid  (cmd_valid_w),
      .cmd_pop    (cmd_pop_w),
      .cmd_word   (cmd_word_w),
      .cmd_idx    (cmd_idx_w)
   );

   mcc_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid_w),
      .cmd_pop    (cmd_pop_w),
      .cmd_word   (cmd_word_w),
      .cmd_idx    (cmd_idx_w),
      .clear_busy (clear_busy_w),
      .rsp_full   (rsp_full_w),
      .rsp_push   (rsp_push_w),
      .rsp_word   (rsp_in_w)
   );

   // response queue
   mcc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSPQ_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push_w),
      .push_word (rsp_in_w),
      .full      (rsp_full_w),
      .pop       (pop),
      .empty     (empty),
      .pop_word  (rsp_word)
   );

   // a response never meets a full response queue
   assert property (@(posedge clock) disable iff (reset) rsp_push_w |-> !rsp_full_w)
      else $error("response pushed into full queue");

   // every command taken yields a response in the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd_pop_w |=> rsp_push_w)
      else $error("command without response");

   // no response without a command taken in the cycle before
   assert property (@(posedge clock) disable iff (reset) rsp_push_w |-> $past(cmd_pop_w))
      else $error("response without command");

   // nothing comes out while the tag store is swept
   assert property (@(posedge clock) disable iff (reset)
                    clear_busy_w |-> (empty && !rsp_push_w && full))
      else $error("activity during tag sweep");

endmodule

// ===== hw/rtl/mcc_fifo.sv =====
// ----------------------------------------------------------------------------
// Metric cache queue
// Small register queue; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module mcc_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_word,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   // handshake qualification
   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign count_in = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   assign pop_word = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + AW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + AW'(1);
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_word;
   end

endmodule

// ===== hw/rtl/mcc_front.sv =====
// ----------------------------------------------------------------------------
// Metric cache front end
// Accepts request words, decodes the mode, computes the table index and
// queues the command for the back end.
// ----------------------------------------------------------------------------
module mcc_front #(
   parameter int ENTRIES = mcc_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  mcc_pkg::req_type           req_word,
   input  logic                       clear_busy,
   output logic                       cmd_valid,
   input  logic                       cmd_pop,
   output mcc_pkg::cmd_type           cmd_word,
   output logic [$clog2(ENTRIES)-1:0] cmd_idx
);
   import mcc_pkg::*;

   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int HASH_SHIFT = 12;
   localparam int QW         = IDX_W + $bits(cmd_type);

   cmd_type           dec;
   logic [31:0]       folded;
   logic [IDX_W-1:0]  idx;
   logic              q_full, q_empty, q_push;
   logic [QW-1:0]     q_out;

   // mode decode
   always_comb begin
      dec.obj    = req_word.obj_addr;
      dec.text   = req_word.text_addr;
      dec.hash   = req_word.text_hash;
      dec.value  = req_word.fill_value;
      dec.height = (req_word.mode == MODE_LOOKUP_H) || (req_word.mode == MODE_FILL_H);
      case (req_word.mode)
         MODE_LOOKUP_W: dec.op = OP_LOOKUP;
         MODE_LOOKUP_H: dec.op = OP_LOOKUP;
         MODE_FILL_W:   dec.op = OP_FILL;
         MODE_FILL_H:   dec.op = OP_FILL;
         MODE_INVAL:    dec.op = OP_INVAL;
         MODE_TICK:     dec.op = OP_TICK;
         default:       dec.op = OP_NONE;
      endcase
   end

   // index: address folded with its upper bits
   assign folded = req_word.obj_addr ^ (req_word.obj_addr >> HASH_SHIFT);
   assign idx    = folded[IDX_W-1:0];

   // no requests while the tag store is being swept
   assign full   = q_full | clear_busy;
   assign q_push = push & ~full;

   mcc_fifo #(
      .WIDTH (QW),
      .DEPTH (CMDQ_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word ({idx, dec}),
      .full      (q_full),
      .pop       (cmd_pop),
      .empty     (q_empty),
      .pop_word  (q_out)
   );

   assign cmd_valid         = ~q_empty;
   assign {cmd_idx, cmd_word} = q_out;

endmodule

// ===== hw/rtl/mcc_back.sv =====
// ----------------------------------------------------------------------------
// Metric cache back end
// Holds the tag and metric stores and the frame counter; runs each command
// as a read cycle followed by a compare/write cycle.
// ----------------------------------------------------------------------------
module mcc_back #(
   parameter int ENTRIES = mcc_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_pop,
   input  mcc_pkg::cmd_type           cmd_word,
   input  logic [$clog2(ENTRIES)-1:0] cmd_idx,
   output logic                       clear_busy,
   input  logic                       rsp_full,
   output logic                       rsp_push,
   output mcc_pkg::rsp_type           rsp_word
);
   import mcc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // stores
   tag_row_type tag_mem    [ENTRIES];
   logic [63:0] width_mem  [ENTRIES];
   logic [63:0] height_mem [ENTRIES];

   state_type        state_ff;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [31:0]      frame_ff, frame_in;
   cmd_type          cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   tag_row_type      row_rd_ff;
   logic [63:0]      wword_rd_ff, hword_rd_ff;

   logic             issue, exec, same;
   logic             tag_we, w_we, h_we;
   logic [IDX_W-1:0] tag_waddr;
   tag_row_type      tag_wdata;
   logic             hit;
   logic [63:0]      value;

   // control
   assign issue      = (state_ff == ST_IDLE) && cmd_valid && !rsp_full;
   assign exec       = (state_ff == ST_EXEC);
   assign cmd_pop    = issue;
   assign clear_busy = (state_ff == ST_CLEAR);
   assign clr_idx_in = clr_idx_ff + IDX_W'(1);
   assign frame_in   = frame_ff + 32'd1;

   // full tag match against the current frame
   assign same = (row_rd_ff.obj == cmd_ff.obj) && (row_rd_ff.text == cmd_ff.text) &&
                 (row_rd_ff.hash == cmd_ff.hash) && (row_rd_ff.frame == frame_ff);

   // execute: compare, build write data, form the response
   always_comb begin
      tag_we    = 1'b0;
      tag_waddr = idx_ff;
      tag_wdata = row_rd_ff;
      w_we      = 1'b0;
      h_we      = 1'b0;
      hit       = 1'b0;
      value     = '0;
      if (state_ff == ST_CLEAR) begin
         tag_we    = 1'b1;
         tag_waddr = clr_idx_ff;
         tag_wdata = '0;
      end else if (exec) begin
         case (cmd_ff.op)
            OP_LOOKUP: begin
               if (same && (cmd_ff.height ? row_rd_ff.h_valid : row_rd_ff.w_valid)) begin
                  hit   = 1'b1;
                  value = cmd_ff.height ? hword_rd_ff : wword_rd_ff;
               end
            end
            OP_FILL: begin
               tag_we          = 1'b1;
               tag_wdata.obj   = cmd_ff.obj;
               tag_wdata.text  = cmd_ff.text;
               tag_wdata.hash  = cmd_ff.hash;
               tag_wdata.frame = frame_ff;
               // a new tag drops the other metric
               if (cmd_ff.height) begin
                  h_we              = 1'b1;
                  tag_wdata.h_valid = 1'b1;
                  tag_wdata.w_valid = same & row_rd_ff.w_valid;
               end else begin
                  w_we              = 1'b1;
                  tag_wdata.w_valid = 1'b1;
                  tag_wdata.h_valid = same & row_rd_ff.h_valid;
               end
            end
            OP_INVAL: begin
               if (row_rd_ff.obj == cmd_ff.obj) begin
                  tag_we    = 1'b1;
                  tag_wdata = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // tag store
   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
      if (issue)  row_rd_ff <= tag_mem[cmd_idx];
   end

   // metric stores
   always_ff @(posedge clock) begin
      if (w_we)  width_mem[idx_ff] <= cmd_ff.value;
      if (issue) wword_rd_ff <= width_mem[cmd_idx];
   end

   always_ff @(posedge clock) begin
      if (h_we)  height_mem[idx_ff] <= cmd_ff.value;
      if (issue) hword_rd_ff <= height_mem[cmd_idx];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
         frame_ff   <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_in;
               if (clr_idx_ff == IDX_W'(ENTRIES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (issue) begin
                  cmd_ff   <= cmd_word;
                  idx_ff   <= cmd_idx;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (cmd_ff.op == OP_TICK) frame_ff <= frame_in;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_push              = exec;
   assign rsp_word.hit          = hit;
   assign rsp_word.result_value = value;

endmodule

// ===== tb/metric_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metric cache checker
// Watches the request and response channels of the metric cache. It keeps
// its own copy of the tag store and metric words, works out the answer to
// every request taken, and compares each response word in order.
// ----------------------------------------------------------------------------
module metric_cache_checker #(
   parameter int ENTRIES = mcc_pkg::ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  mcc_pkg::req_type req_word,
   input  logic             empty,
   input  logic             pop,
   input  mcc_pkg::rsp_type rsp_word,
   output int               fail_count,
   output int               pending
);
   import mcc_pkg::*;

   // shadow of the cache contents
   logic [31:0] ent_obj   [ENTRIES];
   logic [31:0] ent_text  [ENTRIES];
   logic [31:0] ent_hash  [ENTRIES];
   logic [31:0] ent_frame [ENTRIES];
   logic [63:0] w_word    [ENTRIES];
   logic [63:0] h_word    [ENTRIES];
   logic        w_ok      [ENTRIES];
   logic        h_ok      [ENTRIES];
   logic [31:0] frame_now;

   // answers owed by the block, oldest first
   rsp_type answers_due[$];
   int      mismatches;

   function automatic int unsigned slot_of(logic [31:0] a);
      return (a ^ (a >> 12)) & (ENTRIES - 1);
   endfunction

   // apply one request to the shadow and return the word it should produce
   function automatic rsp_type cache_answer(req_type r);
      int unsigned s;
      logic        same;
      rsp_type     ans;
      s    = slot_of(r.obj_addr);
      same = ent_obj[s] == r.obj_addr && ent_text[s] == r.text_addr &&
             ent_hash[s] == r.text_hash && ent_frame[s] == frame_now;
      ans  = '0;
      case (r.mode)
         MODE_LOOKUP_W: begin
            if (same && w_ok[s]) begin
               ans.hit          = 1'b1;
               ans.result_value = w_word[s];
            end
         end
         MODE_LOOKUP_H: begin
            if (same && h_ok[s]) begin
               ans.hit          = 1'b1;
               ans.result_value = h_word[s];
            end
         end
         MODE_FILL_W, MODE_FILL_H: begin
            ent_obj[s]   = r.obj_addr;
            ent_text[s]  = r.text_addr;
            ent_hash[s]  = r.text_hash;
            ent_frame[s] = frame_now;
            // a new tag must not inherit the other metric
            if (r.mode == MODE_FILL_W) begin
               w_word[s] = r.fill_value;
               w_ok[s]   = 1'b1;
               if (!same) h_ok[s] = 1'b0;
            end else begin
               h_word[s] = r.fill_value;
               h_ok[s]   = 1'b1;
               if (!same) w_ok[s] = 1'b0;
            end
         end
         MODE_INVAL: begin
            if (ent_obj[s] == r.obj_addr) begin
               ent_obj[s]   = '0;
               ent_text[s]  = '0;
               ent_hash[s]  = '0;
               ent_frame[s] = '0;
               w_ok[s]      = 1'b0;
               h_ok[s]      = 1'b0;
            end
         end
         MODE_TICK: frame_now = frame_now + 32'd1;
         default: ;
      endcase
      return ans;
   endfunction

   // track requests and responses at each edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            ent_obj[i]   = '0;
            ent_text[i]  = '0;
            ent_hash[i]  = '0;
            ent_frame[i] = '0;
            w_word[i]    = '0;
            h_word[i]    = '0;
            w_ok[i]      = 1'b0;
            h_ok[i]      = 1'b0;
         end
         frame_now = '0;
         answers_due.delete();
         mismatches = 0;
      end else begin
         if (push && !full) answers_due.push_back(cache_answer(req_word));
         if (pop && !empty) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response word with nothing outstanding: hit=%b value=%h",
                        $time, rsp_word.hit, rsp_word.result_value);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_word.hit !== want.hit) begin
                  $display("%0t: hit mismatch: expected %b, got %b",
                           $time, want.hit, rsp_word.hit);
                  mismatches++;
               end
               if (rsp_word.result_value !== want.result_value) begin
                  $display("%0t: result_value mismatch: expected %h, got %h",
                           $time, want.result_value, rsp_word.result_value);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= answers_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metric cache testbench
// Drives a directed sequence and then random lookups, fills, invalidates and
// frame ticks into the metric cache, with random gaps and stalls on both
// channels. The checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_top;
   import mcc_pkg::*;

   localparam int         RANDOM_WORDS = 2000;
   localparam int         POOL_SIZE    = 16;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam logic [2:0] MODE_SPARE6  = 3'd6;
   localparam logic [2:0] MODE_SPARE7  = 3'd7;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_word = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_word;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;
   bit      quiet_send  = 1'b0;
   bit      quiet_recv  = 1'b0;

   // tags that the random part keeps coming back to
   req_type pool [POOL_SIZE];

   direct_mapped_metric_cache_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

   metric_cache_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_word   (req_word),
      .empty      (empty),
      .pop        (pop),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_type make_req(logic [2:0] mode, logic [31:0] obj,
                                        logic [31:0] text, logic [31:0] hash,
                                        logic [63:0] value);
      req_type r;
      r.mode       = mode;
      r.obj_addr   = obj;
      r.text_addr  = text;
      r.text_hash  = hash;
      r.fill_value = value;
      return r;
   endfunction

   // flip pattern that keeps the cache index of an address unchanged
   function automatic logic [31:0] collide_mask();
      logic [31:0] m;
      if ($urandom_range(0, 1)) begin
         m = $urandom_range(1, 2047);
         return (m << 12) | m;
      end
      m = $urandom_range(1, 511);
      return m << 23;
   endfunction

   function automatic req_type random_tag();
      req_type     r;
      int unsigned j;
      j = $urandom_range(0, POOL_SIZE - 1);
      r = '0;
      r.obj_addr  = $urandom_range(0, 1) ? pool[j].obj_addr ^ collide_mask() : $urandom;
      r.text_addr = ($urandom_range(0, 3) == 0) ? pool[j].text_addr : $urandom;
      r.text_hash = ($urandom_range(0, 3) == 0) ? pool[j].text_hash : $urandom;
      return r;
   endfunction

   // one random request, mostly built on the tag pool
   function automatic req_type next_request();
      req_type     r;
      int unsigned k;
      int unsigned pick;
      k    = $urandom_range(0, POOL_SIZE - 1);
      r    = pool[k];
      r.fill_value = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.mode = $urandom_range(0, 1) ? MODE_LOOKUP_H : MODE_LOOKUP_W;
         // near miss on one tag part
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: r.obj_addr  ^= 32'd1 << $urandom_range(0, 31);
               1: r.text_addr ^= 32'd1 << $urandom_range(0, 31);
               default: r.text_hash ^= 32'd1 << $urandom_range(0, 31);
            endcase
         end
      end else if (pick < 65) begin
         r.mode = $urandom_range(0, 1) ? MODE_FILL_H : MODE_FILL_W;
      end else if (pick < 72) begin
         r.mode = MODE_INVAL;
         if ($urandom_range(0, 2) == 0) r.obj_addr ^= collide_mask();
      end else if (pick < 74) begin
         r.mode = MODE_TICK;
      end else if (pick < 85) begin
         // noise, unused modes among it
         r = make_req(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                      {$urandom, $urandom});
         if (pick < 77) r.mode = $urandom_range(0, 1) ? MODE_SPARE7 : MODE_SPARE6;
      end else begin
         // new tag into the pool, often sharing an index or tag part
         pool[k] = random_tag();
         r = pool[k];
         r.mode       = $urandom_range(0, 1) ? MODE_FILL_H : MODE_FILL_W;
         r.fill_value = {$urandom, $urandom};
      end
      return r;
   endfunction

   // offer one word and wait until it is taken
   task automatic send_word(input req_type w);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full);
   endtask

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin : drain
      int wait_cycles;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         wait_cycles = quiet_recv ? 0 : $urandom_range(0, 6);
         if (taken == 400) wait_cycles = HOLD_CYCLES;
         if (wait_cycles > 0) begin
            pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         taken++;
         if (taken % 64 == 0) quiet_recv = ($urandom_range(0, 3) == 0);
      end
   end

   // request side and verdict
   initial begin : stimulus
      logic [31:0] a;
      logic [31:0] b;
      a = 32'hFFFF_FFFF;
      b = 32'h7FFF_FFFF;        // same index as a
      for (int i = 0; i < POOL_SIZE; i++)
         pool[i] = make_req(MODE_LOOKUP_W, $urandom, $urandom, $urandom, '0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, hits on both metrics, tag parts, collisions,
      // invalidate with and without match, frame staleness, unused modes
      send_word(make_req(MODE_LOOKUP_W, '0, '0, '0, '0));
      send_word(make_req(MODE_FILL_W,   a, a, a, '1));
      send_word(make_req(MODE_LOOKUP_W, a, a, a, '0));
      send_word(make_req(MODE_LOOKUP_H, a, a, a, '0));
      send_word(make_req(MODE_FILL_H,   a, a, a, '0));
      send_word(make_req(MODE_LOOKUP_H, a, a, a, '1));
      send_word(make_req(MODE_LOOKUP_W, a, a ^ 32'd1, a, '0));
      send_word(make_req(MODE_LOOKUP_W, a, a, '0, '0));
      send_word(make_req(MODE_FILL_W,   b, '0, '0, 64'h0123_4567_89AB_CDEF));
      send_word(make_req(MODE_LOOKUP_H, b, '0, '0, '0));
      send_word(make_req(MODE_LOOKUP_W, b, '0, '0, '0));
      send_word(make_req(MODE_LOOKUP_W, a, a, a, '0));
      send_word(make_req(MODE_INVAL,    a, a, a, '0));
      send_word(make_req(MODE_LOOKUP_W, b, '0, '0, '0));
      send_word(make_req(MODE_FILL_H,   b, '0, '0, 64'hFEDC_BA98_7654_3210));
      send_word(make_req(MODE_LOOKUP_W, b, '0, '0, '0));
      send_word(make_req(MODE_INVAL,    b, '0, '0, '0));
      send_word(make_req(MODE_LOOKUP_W, b, '0, '0, '0));
      send_word(make_req(MODE_LOOKUP_W, '0, '0, '0, '0));
      send_word(make_req(MODE_FILL_W,   '0, '0, '0, 64'd1));
      send_word(make_req(MODE_LOOKUP_W, '0, '0, '0, '0));
      send_word(make_req(MODE_TICK,     '0, '0, '0, '0));
      send_word(make_req(MODE_LOOKUP_W, '0, '0, '0, '0));
      send_word(make_req(MODE_FILL_H,   '0, '0, '0, '1));
      send_word(make_req(MODE_LOOKUP_W, '0, '0, '0, '0));
      send_word(make_req(MODE_LOOKUP_H, '0, '0, '0, '0));
      send_word(make_req(MODE_SPARE6,   a, a, a, '1));
      send_word(make_req(MODE_SPARE7,   a, a, a, '1));

      // random part
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 50 == 0) quiet_send = ($urandom_range(0, 3) == 0);
         // drain completely once mid-run
         if (n == 1200) begin
            push <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         send_word(next_request());
      end
      push <= 1'b0;

      // let the last responses come out
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
